// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Each macro expects clk and rst_n to be visible in the module that uses it.

`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/tmp_pkg.sv
`timescale 1ns / 1ps

package tmp_pkg;

    localparam int MAX_ROWS_DEFAULT = 64;
    localparam int MAX_COLS_DEFAULT = 64;

    localparam int ELEM_W     = 8;
    localparam int NIBBLE_W   = 4;
    localparam int DIM_W      = 7;
    localparam int DIM_MAX    = 127;
    localparam int OFF_W      = 6;
    localparam int COORD_W    = 8;
    localparam int TILE_LIMIT = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_INSIDE_TILE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_TILE_ORDER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_PAIRS     = 3'd6;

    localparam logic [DIM_W-1:0] RESET_DIM         = 7'd64;
    localparam logic [DIM_W-1:0] RESET_TILE_HEIGHT = 7'd16;
    localparam logic [DIM_W-1:0] RESET_TILE_WIDTH  = 7'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RD_LO,
        S_RD_HI,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic mul;
        logic rd_lo;
        logic rd_hi;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

// File: design/tmp_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          command,
    output logic          in_ready,
    input  tmp_pkg::stat_t stat,
    output tmp_pkg::cmd_t  cmd
);
    import tmp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (command == CMD_REQUEST))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_RD_LO;
            S_RD_LO: state_next = S_RD_HI;
            S_RD_HI: state_next = S_OUT;
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.load  = in_valid && (command == CMD_LOAD);
                cmd.start = in_valid && (command == CMD_REQUEST);
            end
            S_MUL:   cmd.mul   = 1'b1;
            S_RD_LO: cmd.rd_lo = 1'b1;
            S_RD_HI: cmd.rd_hi = 1'b1;
            S_OUT:   cmd.out_load = stat.out_free;
            default: cmd = '0;
        endcase
    end

    `ASSERT_ALWAYS(a_one_cmd, $onehot0(cmd))
    `ASSERT_IMPLIES(a_out_free, cmd.out_load, stat.out_free)
    `ASSERT_NEXT(a_req_busy, in_valid && in_ready && (command == CMD_REQUEST), !in_ready)

endmodule

// File: design/tmp_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmp_datapath #(
    parameter int MAX_ROWS = tmp_pkg::MAX_ROWS_DEFAULT,
    parameter int MAX_COLS = tmp_pkg::MAX_COLS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tmp_pkg::cmd_t                  cmd,
    output tmp_pkg::stat_t                 stat,
    input  logic [tmp_pkg::ELEM_W-1:0]     element,
    input  logic                           cfg_write,
    input  logic [tmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [tmp_pkg::ELEM_W-1:0]     packed_value,
    output logic                           last
);
    import tmp_pkg::*;

    localparam int ROW_LIM = (MAX_ROWS < DIM_MAX) ? MAX_ROWS : DIM_MAX;
    localparam int COL_LIM = (MAX_COLS < DIM_MAX) ? MAX_COLS : DIM_MAX;
    localparam int DEPTH   = ROW_LIM * COL_LIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W   = 2 * DIM_W;
    localparam logic [DIM_W-1:0] ROW_RESET = (ROW_LIM < 64) ? DIM_W'(ROW_LIM) : RESET_DIM;
    localparam logic [DIM_W-1:0] COL_RESET = (COL_LIM < 64) ? DIM_W'(COL_LIM) : RESET_DIM;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic [DIM_W-1:0] rows_reg, cols_reg, th_reg, tw_reg;
    logic             swap_in_reg, swap_tile_reg, nibble_reg;

    logic [DIM_W-1:0] ob_reg, ib_reg;
    logic [OFF_W-1:0] r_reg, c_reg;
    logic [ADDR_W-1:0] load_pos_reg;
    logic [DIM_W-1:0]  load_row_reg, load_col_reg;

    logic [DIM_W-1:0] lo_row_reg, lo_col_reg, hi_row_reg, hi_col_reg;
    logic             lo_ok_reg, hi_ok_reg, last_pend_reg;
    logic [ADDR_W-1:0] idx_lo_reg, idx_hi_reg;
    logic [ELEM_W-1:0] rd_data_reg, lo_data_reg;
    logic              out_valid_reg, out_last_reg;
    logic [ELEM_W-1:0] out_value_reg;

    logic [ELEM_W-1:0] mem [DEPTH];

    logic             cfg_hit;
    logic [DIM_W-1:0] oth, otw, oext, ostep, iext, istep;
    logic [COORD_W-1:0] istep_walk;
    logic [OFF_W-1:0] ir, ic, inner_off, outer_off;
    logic [COORD_W-1:0] outer_coord, inner_lo, inner_hi;
    logic [COORD_W-1:0] lo_row, lo_col, hi_row, hi_col;
    logic             hi_exists, lo_ok, hi_ok;
    logic [DIM_W-1:0] c_inc, r_inc;
    logic [COORD_W-1:0] ib_sum, ob_sum;
    logic             c_wrap, r_wrap, ib_wrap, ob_wrap;
    logic [DIM_W-1:0] lcol_inc, lrow_inc;
    logic             lcol_wrap, lrow_wrap;
    logic [IDX_W-1:0] idx_lo_full, idx_hi_full;
    logic [ELEM_W-1:0] lo_val, hi_val, value;

    assign cfg_hit = cfg_write && (cfg_index <= REG_NIBBLE_PAIRS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= ROW_RESET;
            cols_reg      <= COL_RESET;
            th_reg        <= RESET_TILE_HEIGHT;
            tw_reg        <= RESET_TILE_WIDTH;
            swap_in_reg   <= 1'b0;
            swap_tile_reg <= 1'b0;
            nibble_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:        rows_reg <= sat_dim(cfg_data, DIM_W'(ROW_LIM));
                REG_COL_COUNT:        cols_reg <= sat_dim(cfg_data, DIM_W'(COL_LIM));
                REG_TILE_HEIGHT:      th_reg   <= sat_dim(cfg_data, DIM_W'(TILE_LIMIT));
                REG_TILE_WIDTH:       tw_reg   <= sat_dim(cfg_data, DIM_W'(TILE_LIMIT));
                REG_SWAP_INSIDE_TILE: swap_in_reg   <= cfg_data[0];
                REG_SWAP_TILE_ORDER:  swap_tile_reg <= cfg_data[0];
                REG_NIBBLE_PAIRS:     nibble_reg    <= cfg_data[0];
                default:              rows_reg <= rows_reg;
            endcase
        end
    end

    always_comb
    begin
        oth        = swap_in_reg ? tw_reg : th_reg;
        otw        = swap_in_reg ? th_reg : tw_reg;
        oext       = swap_tile_reg ? cols_reg : rows_reg;
        ostep      = swap_tile_reg ? tw_reg : th_reg;
        iext       = swap_tile_reg ? rows_reg : cols_reg;
        istep      = swap_tile_reg ? th_reg : tw_reg;
        istep_walk = nibble_reg ? {istep, 1'b0} : {1'b0, istep};

        ir        = swap_in_reg ? c_reg : r_reg;
        ic        = swap_in_reg ? r_reg : c_reg;
        inner_off = swap_tile_reg ? ir : ic;
        outer_off = swap_tile_reg ? ic : ir;

        outer_coord = {1'b0, ob_reg} + COORD_W'(outer_off);
        inner_lo    = {1'b0, ib_reg} + COORD_W'(inner_off);
        inner_hi    = inner_lo + {1'b0, istep};
        hi_exists   = ({1'b0, ib_reg} + {1'b0, istep}) < {1'b0, iext};

        lo_row = swap_tile_reg ? inner_lo : outer_coord;
        lo_col = swap_tile_reg ? outer_coord : inner_lo;
        hi_row = swap_tile_reg ? inner_hi : outer_coord;
        hi_col = swap_tile_reg ? outer_coord : inner_hi;
        lo_ok  = (lo_row < {1'b0, rows_reg}) && (lo_col < {1'b0, cols_reg});
        hi_ok  = nibble_reg && hi_exists
                 && (hi_row < {1'b0, rows_reg}) && (hi_col < {1'b0, cols_reg});

        c_inc   = {1'b0, c_reg} + DIM_W'(1);
        r_inc   = {1'b0, r_reg} + DIM_W'(1);
        ib_sum  = {1'b0, ib_reg} + istep_walk;
        ob_sum  = {1'b0, ob_reg} + {1'b0, ostep};
        c_wrap  = c_inc >= otw;
        r_wrap  = r_inc >= oth;
        ib_wrap = ib_sum >= {1'b0, iext};
        ob_wrap = ob_sum >= {1'b0, oext};

        lcol_inc  = load_col_reg + DIM_W'(1);
        lrow_inc  = load_row_reg + DIM_W'(1);
        lcol_wrap = lcol_inc >= cols_reg;
        lrow_wrap = lrow_inc >= rows_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_reg       <= '0;
            ib_reg       <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            load_pos_reg <= '0;
            load_row_reg <= '0;
            load_col_reg <= '0;
        end
        else if (cfg_hit)
        begin
            ob_reg       <= '0;
            ib_reg       <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            load_pos_reg <= '0;
            load_row_reg <= '0;
            load_col_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (lcol_wrap)
                begin
                    load_col_reg <= '0;
                    if (lrow_wrap)
                    begin
                        load_row_reg <= '0;
                        load_pos_reg <= '0;
                    end
                    else
                    begin
                        load_row_reg <= lrow_inc;
                        load_pos_reg <= load_pos_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    load_col_reg <= lcol_inc;
                    load_pos_reg <= load_pos_reg + ADDR_W'(1);
                end
            end
            if (cmd.start)
            begin
                if (!c_wrap)
                begin
                    c_reg <= c_inc[OFF_W-1:0];
                end
                else
                begin
                    c_reg <= '0;
                    if (!r_wrap)
                    begin
                        r_reg <= r_inc[OFF_W-1:0];
                    end
                    else
                    begin
                        r_reg <= '0;
                        if (!ib_wrap)
                        begin
                            ib_reg <= ib_sum[DIM_W-1:0];
                        end
                        else
                        begin
                            ib_reg <= '0;
                            ob_reg <= ob_wrap ? '0 : ob_sum[DIM_W-1:0];
                        end
                    end
                end
            end
        end
    end

    assign idx_lo_full = IDX_W'(lo_row_reg) * IDX_W'(cols_reg) + IDX_W'(lo_col_reg);
    assign idx_hi_full = IDX_W'(hi_row_reg) * IDX_W'(cols_reg) + IDX_W'(hi_col_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lo_row_reg    <= lo_row[DIM_W-1:0];
            lo_col_reg    <= lo_col[DIM_W-1:0];
            hi_row_reg    <= hi_row[DIM_W-1:0];
            hi_col_reg    <= hi_col[DIM_W-1:0];
            lo_ok_reg     <= lo_ok;
            hi_ok_reg     <= hi_ok;
            last_pend_reg <= c_wrap && r_wrap && ib_wrap && ob_wrap;
        end
        if (cmd.mul)
        begin
            idx_lo_reg <= idx_lo_full[ADDR_W-1:0];
            idx_hi_reg <= idx_hi_full[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[load_pos_reg] <= element;
        end
        if (cmd.rd_lo)
        begin
            rd_data_reg <= mem[idx_lo_reg];
        end
        else if (cmd.rd_hi)
        begin
            rd_data_reg <= mem[idx_hi_reg];
            lo_data_reg <= rd_data_reg;
        end
    end

    always_comb
    begin
        lo_val = lo_ok_reg ? lo_data_reg : '0;
        hi_val = hi_ok_reg ? rd_data_reg : '0;
        value  = nibble_reg ? {hi_val[NIBBLE_W-1:0], lo_val[NIBBLE_W-1:0]} : lo_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg <= value;
            out_last_reg  <= last_pend_reg;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign packed_value  = out_value_reg;
    assign last          = out_last_reg;

    `ASSERT_ALWAYS(a_load_col, load_col_reg < cols_reg)
    `ASSERT_ALWAYS(a_walk_col, {1'b0, c_reg} < otw)

endmodule

// File: design/tiled_matrix_pack.sv
// An element load is accepted while idle; the next transfer may follow at once.
// A request for a packed value holds in_ready low while the block takes its steps:
// one to place the tile coordinates, one for the address multiply and two for the
// single store read port (low and high tile), then the result register is written
// once the output is free and out_valid rises with it. Reset (rst_n, async,
// active low) restores the default configuration and restarts both walks.
`timescale 1ns / 1ps

module tiled_matrix_pack #(
    parameter int MAX_ROWS = tmp_pkg::MAX_ROWS_DEFAULT,
    parameter int MAX_COLS = tmp_pkg::MAX_COLS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           command,
    input  logic [tmp_pkg::ELEM_W-1:0]     element,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tmp_pkg::ELEM_W-1:0]     packed_value,
    output logic                           last,
    input  logic                           cfg_write,
    input  logic [tmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tmp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tmp_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .element      (element),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .packed_value (packed_value),
        .last         (last)
    );

endmodule
